// ----- src/sktu_pkg.sv -----
// Shared widths, codes and types for the sorted key index table.
package sktu_pkg;

    localparam int KEY_W = 31;
    localparam int REC_W = 8;
    localparam int ACT_W = 2;
    localparam int STAT_W = 2;
    localparam int CNT_OUT_W = 8;

    localparam int DEFAULT_TABLE_DEPTH = 128;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } entry_t;

endpackage

// ----- src/sktu_req_if.sv -----
// Request channel: action, key and record number.
interface sktu_req_if;
    logic                            valid;
    logic                            ready;
    logic [sktu_pkg::ACT_W-1:0]      action;
    logic [sktu_pkg::KEY_W-1:0]      key;
    logic [sktu_pkg::REC_W-1:0]      record_number;

    modport source (output valid, action, key, record_number, input ready);
    modport sink   (input valid, action, key, record_number, output ready);
endinterface

// ----- src/sktu_rsp_if.sv -----
// Response channel: status, found record and entry count.
interface sktu_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sktu_pkg::STAT_W-1:0]     status;
    logic [sktu_pkg::REC_W-1:0]      found_record;
    logic [sktu_pkg::CNT_OUT_W-1:0]  entry_count;

    modport source (output valid, status, found_record, entry_count, input ready);
    modport sink   (input valid, status, found_record, entry_count, output ready);
endinterface

// ----- src/sktu_mem.sv -----
// Entry memory: one write port, one registered read port.
module sktu_mem #(
    parameter int TABLE_DEPTH = sktu_pkg::DEFAULT_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  sktu_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output sktu_pkg::entry_t     rd_data
);

    sktu_pkg::entry_t mem [TABLE_DEPTH];
    sktu_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/sorted_key_index_table_unit.sv -----
// Top level of the sorted key index table: sequencer, counters and result stage.
//
//  beat     dir  fields                                   accepted when
//  req      in   action, key, record_number               valid & ready
//  rsp      out  status, found_record, entry_count        valid & ready
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Insert: shifts each entry at or above the slot up by one, one shifted entry
// per cycle through the single write port of the entry memory.
// Lookup: one binary-search probe per registered memory read, at most
// log2(depth)+1 probes. Clear and unused actions go straight to the
// finish step.
// Reset empties the table at once (count only); memory contents are not touched.
// A result waiting on rsp holds the sequencer in its finish step, not the input.
module sorted_key_index_table_unit #(
    parameter int TABLE_DEPTH = sktu_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    sktu_req_if.sink      req,
    sktu_rsp_if.source    rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_START = 3'd1;
    localparam logic [2:0] S_INS_LOOP  = 3'd2;
    localparam logic [2:0] S_INS_LAST  = 3'd3;
    localparam logic [2:0] S_LK_PROBE  = 3'd4;
    localparam logic [2:0] S_LK_CMP    = 3'd5;
    localparam logic [2:0] S_FINISH    = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic [CW-1:0]                    used_reg, used_next;
    logic [CW-1:0]                    j_reg, j_next;      // slot being filled on insert
    logic [CW-1:0]                    lo_reg, lo_next;
    logic [CW-1:0]                    hi_reg, hi_next;    // exclusive upper bound
    logic [AW-1:0]                    mid_reg, mid_next;
    logic [sktu_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [sktu_pkg::REC_W-1:0]       rec_reg, rec_next;
    logic [sktu_pkg::STAT_W-1:0]      res_status_reg, res_status_next;
    logic [sktu_pkg::REC_W-1:0]       res_rec_reg, res_rec_next;

    logic                             out_valid_reg, out_valid_next;
    logic [sktu_pkg::STAT_W-1:0]      out_status_reg, out_status_next;
    logic [sktu_pkg::REC_W-1:0]       out_rec_reg, out_rec_next;
    logic [sktu_pkg::CNT_OUT_W-1:0]   out_count_reg, out_count_next;

    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    sktu_pkg::entry_t                 wr_data;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    sktu_pkg::entry_t                 rd_data;
    sktu_pkg::entry_t                 new_entry;

    logic                             in_fire;
    logic [CW:0]                      mid_sum;

    sktu_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;

    assign new_entry.key = key_reg;
    assign new_entry.rec = rec_reg;

    // floor((lo + hi_incl) / 2) with hi_incl = hi - 1; only used when lo < hi
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW + 1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        rec_next        = rec_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_entry;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next        = req.key;
                    rec_next        = req.record_number;
                    res_status_next = sktu_pkg::ST_OK;
                    res_rec_next    = '0;
                    case (req.action)
                        sktu_pkg::ACT_INSERT:
                        begin
                            if (used_reg == CW'(TABLE_DEPTH))
                            begin
                                res_status_next = sktu_pkg::ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_INS_START;
                            end
                        end
                        sktu_pkg::ACT_LOOKUP:
                        begin
                            lo_next    = '0;
                            hi_next    = used_reg;
                            state_next = S_LK_PROBE;
                        end
                        sktu_pkg::ACT_CLEAR:
                        begin
                            used_next  = '0;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_INS_START:
            begin
                if (used_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    used_next  = used_reg + CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(used_reg - CW'(1));
                    j_next     = used_reg;
                    state_next = S_INS_LOOP;
                end
            end

            // rd_data holds entry j-1: either the new pair lands at j,
            // or entry j-1 moves up to j and the scan steps down
            S_INS_LOOP:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(j_reg);
                if (key_reg > rd_data.key)
                begin
                    used_next  = used_reg + CW'(1);
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_data = rd_data;
                    if (j_reg == CW'(1))
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(j_reg - CW'(2));
                        j_next  = j_reg - CW'(1);
                    end
                end
            end

            S_INS_LAST:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                used_next  = used_reg + CW'(1);
                state_next = S_FINISH;
            end

            S_LK_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid_sum[AW:1];
                    mid_next   = mid_sum[AW:1];
                    state_next = S_LK_CMP;
                end
                else
                begin
                    res_status_next = sktu_pkg::ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end

            S_LK_CMP:
            begin
                if (key_reg == rd_data.key)
                begin
                    res_status_next = sktu_pkg::ST_FOUND;
                    res_rec_next    = rd_data.rec;
                    state_next      = S_FINISH;
                end
                else if (key_reg < rd_data.key)
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = S_LK_PROBE;
                end
                else
                begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = S_LK_PROBE;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result stage: loaded from the finish step once the slot is free
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_count_next  = out_count_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_FINISH && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_rec_next    = res_rec_reg;
            out_count_next  = sktu_pkg::CNT_OUT_W'(used_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        rec_reg        <= rec_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        out_status_reg <= out_status_next;
        out_rec_reg    <= out_rec_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_record = out_rec_reg;
    assign rsp.entry_count  = out_count_reg;

endmodule

// ----- tb/sktu_table_check.sv -----
// Scoreboard for the sorted key index table: shadow table, answer queue, field compare.
`timescale 1ns / 100ps

module sktu_table_check #(
    parameter int TABLE_DEPTH = sktu_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    sktu_req_if         req,
    sktu_rsp_if         rsp,
    input  logic        end_of_test,
    output int unsigned fail_count
);

    typedef struct packed {
        logic [sktu_pkg::STAT_W-1:0]    status;
        logic [sktu_pkg::REC_W-1:0]     found_record;
        logic [sktu_pkg::CNT_OUT_W-1:0] entry_count;
    } table_answer_t;

    // shadow copy of the table, kept sorted by key
    logic [sktu_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [sktu_pkg::REC_W-1:0] shadow_recs [TABLE_DEPTH];
    int                         shadow_used;

    table_answer_t    expected_answers [$];
    bit               tail_checked;

    // apply one request to the shadow table, return the answer it must give
    function automatic table_answer_t table_step(logic [sktu_pkg::ACT_W-1:0] act,
                                                 logic [sktu_pkg::KEY_W-1:0] k,
                                                 logic [sktu_pkg::REC_W-1:0] r);
        table_answer_t ans;
        int            slot;
        int            lo;
        int            hi;
        int            mid;
        ans = '0;
        ans.status = sktu_pkg::ST_OK;
        case (act)
            sktu_pkg::ACT_INSERT:
            begin
                if (shadow_used >= TABLE_DEPTH)
                begin
                    ans.status = sktu_pkg::ST_FULL;
                end
                else
                begin
                    // last entry with a smaller key; equal keys end up above the new one
                    slot = 0;
                    for (int j = shadow_used; j > 0; j--)
                    begin
                        if (k > shadow_keys[j-1])
                        begin
                            slot = j;
                            break;
                        end
                    end
                    for (int j = shadow_used; j > slot; j--)
                    begin
                        shadow_keys[j] = shadow_keys[j-1];
                        shadow_recs[j] = shadow_recs[j-1];
                    end
                    shadow_keys[slot] = k;
                    shadow_recs[slot] = r;
                    shadow_used++;
                end
            end
            sktu_pkg::ACT_LOOKUP:
            begin
                // binary search, midpoint rounded down, first equal probe wins
                ans.status = sktu_pkg::ST_NOT_FOUND;
                lo = 0;
                hi = shadow_used - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (k == shadow_keys[mid])
                    begin
                        ans.status = sktu_pkg::ST_FOUND;
                        ans.found_record = shadow_recs[mid];
                        break;
                    end
                    if (k < shadow_keys[mid])
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                end
            end
            sktu_pkg::ACT_CLEAR:
            begin
                shadow_used = 0;
            end
            default:
            begin
            end
        endcase
        ans.entry_count = shadow_used[sktu_pkg::CNT_OUT_W-1:0];
        return ans;
    endfunction

    function automatic int unsigned check_field(string name, int unsigned want,
                                                int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            shadow_used = 0;
            expected_answers.delete();
            fail_count = 0;
            tail_checked = 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_answers.push_back(table_step(req.action, req.key, req.record_number));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected beat, status %0d record %0d count %0d",
                             $time, rsp.status, rsp.found_record, rsp.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    fail_count += check_field("status", 32'(want.status),
                                              32'(rsp.status));
                    fail_count += check_field("found_record", 32'(want.found_record),
                                              32'(rsp.found_record));
                    fail_count += check_field("entry_count", 32'(want.entry_count),
                                              32'(rsp.entry_count));
                end
            end
            if (end_of_test && !tail_checked)
            begin
                tail_checked = 1'b1;
                if (expected_answers.size() != 0)
                begin
                    $display("%0t: %0d answers never arrived", $time,
                             expected_answers.size());
                    fail_count += expected_answers.size();
                end
            end
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the sorted key index table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    localparam int TABLE_DEPTH = sktu_pkg::DEFAULT_TABLE_DEPTH;
    // action code 3 has no meaning; the block must answer it and leave the table alone
    localparam logic [sktu_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [sktu_pkg::KEY_W-1:0] KEY_MAX = {sktu_pkg::KEY_W{1'b1}};
    localparam logic [sktu_pkg::REC_W-1:0] REC_MAX = {sktu_pkg::REC_W{1'b1}};
    // worst insert shifts the whole table
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 50;
    // ~1000 beats, each at its worst case, taken several times over
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned ITEMS_PER_PHASE = 270;

    logic        clk;
    logic        rst_n;
    logic        end_of_test;
    int unsigned fail_count;

    sktu_req_if req_ch ();
    sktu_rsp_if rsp_ch ();

    sorted_key_index_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sktu_table_check #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .end_of_test (end_of_test),
        .fail_count  (fail_count)
    );

    // idle percentages per side, changed between phases
    int          snd_idle_pct;
    int          rcv_idle_pct;

    // beat counters on both channels, used to drain the block
    int unsigned req_beats;
    int unsigned rsp_beats;
    int unsigned cycle_count;

    // rough view of table contents, only to steer stimulus (not for checking)
    logic [sktu_pkg::KEY_W-1:0] live_keys [$];
    int                         table_fill;
    int unsigned                stim_items;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (req_ch.valid && req_ch.ready)
            req_beats <= req_beats + 1;
        if (rsp_ch.valid && rsp_ch.ready)
            rsp_beats <= rsp_beats + 1;
    end

    // receiver side: random back-pressure, held low through reset
    always @(posedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(0, 99) >= rcv_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_key_index_table_unit test failed");
            $finish;
        end
    end

    // random field values cut to the field widths
    function automatic logic [sktu_pkg::KEY_W-1:0] rand_key();
        logic [31:0] r;
        r = $urandom();
        return r[sktu_pkg::KEY_W-1:0];
    endfunction

    function automatic logic [sktu_pkg::REC_W-1:0] rand_rec();
        logic [31:0] r;
        r = $urandom();
        return r[sktu_pkg::REC_W-1:0];
    endfunction

    // Send one request beat. The sender may idle first; valid stays high
    // after acceptance so back-to-back beats keep it up with no glitch.
    task automatic send_beat(input logic [sktu_pkg::ACT_W-1:0] act,
                             input logic [sktu_pkg::KEY_W-1:0] k,
                             input logic [sktu_pkg::REC_W-1:0] r);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.key           <= k;
        req_ch.record_number <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // beat taken at this edge; track what the table roughly holds
        case (act)
            sktu_pkg::ACT_INSERT:
            begin
                if (table_fill < TABLE_DEPTH)
                begin
                    table_fill++;
                    live_keys.push_back(k);
                end
            end
            sktu_pkg::ACT_CLEAR:
            begin
                table_fill = 0;
                live_keys.delete();
            end
            default:
            begin
            end
        endcase
        if (act != ACT_UNUSED)
            stim_items++;
    endtask

    // Drop valid and hold off until every answer is back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (rsp_beats < req_beats)
            @(posedge clk);
    endtask

    // Key for an insert: mix of wide random, a small pool that collides
    // often, the range ends, and neighbors of keys already stored.
    function automatic logic [sktu_pkg::KEY_W-1:0] pick_new_key();
        logic [31:0] k;
        k = $urandom();
        case ($urandom_range(0, 3))
            1: k = $urandom_range(0, 15);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: k = 32'd0;
                    1: k = {1'b0, KEY_MAX};
                    2: k = {1'b0, KEY_MAX - 31'd1};
                    default: k = 32'd1;
                endcase
            end
            3:
            begin
                if (live_keys.size() > 0)
                    k = {1'b0, live_keys[$urandom_range(0, live_keys.size() - 1)]}
                        + $urandom_range(0, 2) - 32'd1;
            end
            default:
            begin
            end
        endcase
        return k[sktu_pkg::KEY_W-1:0];
    endfunction

    // Key for a lookup: mostly one that is stored, so searches go deep.
    function automatic logic [sktu_pkg::KEY_W-1:0] pick_probe_key();
        if (live_keys.size() > 0 && $urandom_range(0, 99) < 75)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return pick_new_key();
    endfunction

    // Random traffic in episodes: each starts with a clear, then inserts, lookups,
    // unused actions and (unless filling) clears. A filling episode inserts until
    // the table is full and keeps pushing a few refused inserts after that.
    task automatic run_random(input int unsigned budget, input bit force_fill);
        int unsigned start_items;
        int unsigned run_len;
        int unsigned step;
        int unsigned full_hits;
        int          pick;
        int          ins_pct;
        bit          filling;
        start_items = stim_items;
        while (stim_items - start_items < budget)
        begin
            send_beat(sktu_pkg::ACT_CLEAR, rand_key(), rand_rec());
            filling = force_fill || ($urandom_range(0, 5) == 0);
            force_fill = 1'b0;
            run_len = $urandom_range(4, 40);
            ins_pct = filling ? 70 : 50;
            full_hits = 0;
            step = 0;
            while (filling ? (full_hits < 3) : (step < run_len))
            begin
                pick = $urandom_range(0, 99);
                if (pick < ins_pct)
                begin
                    if (table_fill == TABLE_DEPTH)
                        full_hits++;
                    send_beat(sktu_pkg::ACT_INSERT, pick_new_key(), rand_rec());
                end
                else if (pick < 94)
                    send_beat(sktu_pkg::ACT_LOOKUP, pick_probe_key(), rand_rec());
                else if (pick < 97)
                    send_beat(ACT_UNUSED, rand_key(), rand_rec());
                else if (!filling)
                    send_beat(sktu_pkg::ACT_CLEAR, rand_key(), rand_rec());
                else
                    send_beat(sktu_pkg::ACT_LOOKUP, pick_new_key(), rand_rec());
                step++;
            end
        end
    endtask

    initial
    begin
        // known values on every input from time zero
        rst_n                = 1'b0;
        end_of_test          = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.action        = sktu_pkg::ACT_INSERT;
        req_ch.key           = '0;
        req_ch.record_number = '0;
        rsp_ch.ready         = 1'b0;
        req_beats            = 0;
        rsp_beats            = 0;
        cycle_count          = 0;
        table_fill           = 0;
        stim_items           = 0;
        snd_idle_pct         = 21;
        rcv_idle_pct         = 53;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, key and record extremes, equal keys,
        // record zero found, unused action, clear with junk fields
        send_beat(sktu_pkg::ACT_LOOKUP, '0, '0);
        send_beat(ACT_UNUSED, '0, '0);
        send_beat(sktu_pkg::ACT_INSERT, KEY_MAX, REC_MAX);
        send_beat(sktu_pkg::ACT_INSERT, '0, '0);
        send_beat(sktu_pkg::ACT_INSERT, 31'h4000_0000, 8'd1);
        send_beat(sktu_pkg::ACT_INSERT, 31'h4000_0000, 8'd2);
        send_beat(sktu_pkg::ACT_INSERT, 31'h4000_0000, 8'd128);
        send_beat(sktu_pkg::ACT_LOOKUP, KEY_MAX, '0);
        send_beat(sktu_pkg::ACT_LOOKUP, '0, REC_MAX);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'h4000_0000, '0);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'h3FFF_FFFF, '0);
        send_beat(sktu_pkg::ACT_LOOKUP, KEY_MAX - 31'd1, '0);
        send_beat(ACT_UNUSED, KEY_MAX, REC_MAX);
        send_beat(sktu_pkg::ACT_LOOKUP, KEY_MAX, '0);
        send_beat(sktu_pkg::ACT_CLEAR, '0, '0);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'h4000_0000, '0);
        // descending inserts force a shift of every stored entry
        send_beat(sktu_pkg::ACT_INSERT, 31'd5, 8'h80);
        send_beat(sktu_pkg::ACT_INSERT, 31'd3, 8'h7F);
        send_beat(sktu_pkg::ACT_INSERT, 31'd1, 8'h55);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'd3, '0);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'd1, '0);
        send_beat(sktu_pkg::ACT_CLEAR, KEY_MAX, REC_MAX);
        send_beat(sktu_pkg::ACT_LOOKUP, 31'd5, '0);
        wait_for_drain();

        // phase 1: sender idles lightly, receiver stalls a lot
        run_random(ITEMS_PER_PHASE, 1'b0);
        wait_for_drain();

        // phase 2: sides swapped
        snd_idle_pct = 53;
        rcv_idle_pct = 21;
        run_random(ITEMS_PER_PHASE, 1'b0);
        wait_for_drain();

        // phase 3: full rate, and at least one table filled to the top
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE, 1'b1);
        wait_for_drain();

        // catch any stray late beats, then close out the queue check
        repeat (TAIL_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        if (fail_count == 0)
            $display("sorted_key_index_table_unit test passed");
        else
            $display("sorted_key_index_table_unit test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/sktu_pkg.sv
src/sktu_req_if.sv
src/sktu_rsp_if.sv
src/sktu_mem.sv
src/sorted_key_index_table_unit.sv
tb/sktu_table_check.sv
tb/tb_top.sv
